// ----- hdl/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the SMBIOS string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_NONE = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OFFSET = 8'd1;

  localparam logic [7:0] TARGET_TYPE_RST  = 8'd1;
  localparam logic [7:0] FIELD_OFFSET_RST = 8'd4;

  localparam logic [7:0] END_TYPE     = 8'd127;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MIN_LEN      = 4;
  localparam int unsigned HDR_LEN_W    = 32;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    kind_e      kind;
    logic       end_of_run;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/sse_in_stage.sv -----
// ----------------------------------------------------------------------------
// sse_in_stage
// Input register: holds one accepted byte request until the walker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              first_byte_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              final_byte_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output sse_pkg::byte_req_t     req_o
);
  import sse_pkg::*;

  logic      valid_q, valid_d;
  byte_req_t req_q;
  logic      load;

  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= '{first_byte: first_byte_i, data_byte: data_byte_i, final_byte: final_byte_i};
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ----- hdl/sse_walker.sv -----
// ----------------------------------------------------------------------------
// sse_walker
// Table walk state and per-byte decision logic for the string lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_walker #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire sse_pkg::byte_req_t req_i,
  input  wire logic [7:0]         target_type_i,
  input  wire logic [7:0]         field_offset_i,
  output sse_pkg::result_t        res_o
);
  import sse_pkg::*;

  localparam int unsigned LW = LENGTH_BITS;
  localparam logic [7:0] LEN_FIELD_OFS = 8'd1;
  localparam logic [7:0] FMT_START_OFS = 8'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_LEN,
    PH_FORMATTED,
    PH_STRINGS
  } phase_e;

  phase_e        phase_q, phase_d, phase_s;
  logic [LW-1:0] pos_q, pos_d, pos_s;
  logic [LW-1:0] len_q, len_d, len_s;
  logic          ovf_q, ovf_d, ovf_s;
  logic [7:0]    slen_q, slen_d;
  logic [7:0]    off_q, off_d;
  logic          match_q, match_d, match_s;
  logic [7:0]    wanted_q, wanted_d, wanted_s;
  logic [7:0]    count_q, count_d, count_s;
  logic          pz_q, pz_d, pz_s;
  logic          rep_q, rep_d, rep_s;

  logic [HDR_LEN_W-1:0] hdr_shift;
  logic [LW-1:0]        len_acc, len_fin;
  logic                 ovf_acc;
  logic [LW:0]          pos_inc;
  logic [7:0]           b;
  logic [7:0]           wanted_n;
  logic                 verd, chr;
  kind_e                verd_kind;

  assign b = req_i.data_byte;

  // restart on the first byte of a buffer
  assign phase_s  = req_i.first_byte ? PH_HEADER : phase_q;
  assign pos_s    = req_i.first_byte ? '0 : pos_q;
  assign len_s    = req_i.first_byte ? '0 : len_q;
  assign ovf_s    = req_i.first_byte ? 1'b0 : ovf_q;
  assign match_s  = req_i.first_byte ? 1'b0 : match_q;
  assign wanted_s = req_i.first_byte ? 8'd0 : wanted_q;
  assign count_s  = req_i.first_byte ? 8'd0 : count_q;
  assign pz_s     = req_i.first_byte ? 1'b0 : pz_q;
  assign rep_s    = req_i.first_byte ? 1'b0 : rep_q;

  // little-endian length assembly, saturated to the length width
  assign hdr_shift = HDR_LEN_W'(b) << {pos_s[1:0], 3'b000};
  assign len_acc   = len_s | hdr_shift[LW-1:0];
  assign ovf_acc   = ovf_s | (|(hdr_shift >> LW));
  assign len_fin   = ovf_acc ? '1 : len_acc;
  assign pos_inc   = {1'b0, pos_s} + (LW+1)'(1);

  assign wanted_n = (match_s && off_q == field_offset_i) ? b : wanted_s;

  always_comb begin
    phase_d   = phase_s;
    pos_d     = pos_s;
    len_d     = len_s;
    ovf_d     = ovf_s;
    slen_d    = slen_q;
    off_d     = off_q;
    match_d   = match_s;
    wanted_d  = wanted_s;
    count_d   = count_s;
    pz_d      = pz_s;
    rep_d     = rep_s;
    verd      = 1'b0;
    verd_kind = KIND_NONE;
    chr       = 1'b0;
    if (!rep_s) begin
      case (phase_s)
        PH_HEADER: begin
          pos_d = pos_s + LW'(1);
          if (pos_s[2]) begin
            len_d = len_acc;
            ovf_d = ovf_acc;
          end
          if (pos_s[2:0] == 3'(HEADER_BYTES - 1)) begin
            len_d   = len_fin;
            pos_d   = '0;
            phase_d = PH_TYPE;
            match_d = 1'b0;
            if (LW'(MIN_LEN) > len_fin) begin
              verd      = 1'b1;
              verd_kind = KIND_NONE;
            end
          end
        end
        PH_TYPE: begin
          wanted_d = b;
          phase_d  = PH_LEN;
        end
        PH_LEN: begin
          slen_d = b;
          if (b < 8'(MIN_LEN) ||
              ({1'b0, pos_s} + (LW+1)'(b) + (LW+1)'(1)) > {1'b0, len_s}) begin
            verd      = 1'b1;
            verd_kind = KIND_BAD;
          end else if (wanted_s == END_TYPE) begin
            verd      = 1'b1;
            verd_kind = KIND_NONE;
          end else begin
            match_d = (wanted_s == target_type_i) && (field_offset_i < b);
            if (field_offset_i == LEN_FIELD_OFS) begin
              wanted_d = b;
            end
            phase_d = PH_FORMATTED;
            off_d   = FMT_START_OFS;
          end
        end
        PH_FORMATTED: begin
          wanted_d = wanted_n;
          off_d    = off_q + 8'd1;
          if (({1'b0, off_q} + 9'd1) >= {1'b0, slen_q}) begin
            if (match_s && wanted_n == 8'd0) begin
              verd      = 1'b1;
              verd_kind = KIND_NONE;
            end else begin
              phase_d = PH_STRINGS;
              count_d = 8'd1;
              pz_d    = match_s;
            end
          end
        end
        PH_STRINGS: begin
          if (match_s) begin
            if (pz_s && b == 8'd0) begin
              verd      = 1'b1;
              verd_kind = KIND_NONE;
            end else if (count_s == wanted_s) begin
              if (b == 8'd0) begin
                verd      = 1'b1;
                verd_kind = KIND_DONE;
              end else begin
                chr = 1'b1;
              end
              pz_d = 1'b0;
            end else begin
              if (b == 8'd0) begin
                count_d = count_s + 8'd1;
              end
              pz_d = (b == 8'd0);
            end
          end else begin
            if (b == 8'd0 && pz_s) begin
              match_d = 1'b0;
              phase_d = PH_TYPE;
              if ((pos_inc + (LW+1)'(MIN_LEN)) > {1'b0, len_s}) begin
                verd      = 1'b1;
                verd_kind = KIND_NONE;
              end
            end else begin
              pz_d = (b == 8'd0);
            end
          end
        end
        default: ;
      endcase
      if (phase_s != PH_HEADER && !verd) begin
        pos_d = pos_s + LW'(1);
        if (pos_inc >= {1'b0, len_s}) begin
          verd      = 1'b1;
          verd_kind = match_d ? KIND_BAD : KIND_NONE;
        end
      end
      if (!verd && req_i.final_byte) begin
        verd      = 1'b1;
        verd_kind = KIND_BAD;
      end
      if (verd) begin
        rep_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.valid      = verd || chr;
    res_o.kind       = verd ? verd_kind : KIND_CHAR;
    res_o.char_byte  = verd ? 8'd0 : b;
    res_o.end_of_run = verd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      slen_q   <= 8'd0;
      off_q    <= 8'd0;
      match_q  <= 1'b0;
      wanted_q <= 8'd0;
      count_q  <= 8'd0;
      pz_q     <= 1'b0;
      rep_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      slen_q   <= slen_d;
      off_q    <= off_d;
      match_q  <= match_d;
      wanted_q <= wanted_d;
      count_q  <= count_d;
      pz_q     <= pz_d;
      rep_q    <= rep_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sse_out_stage.sv -----
// ----------------------------------------------------------------------------
// sse_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sse_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            char_byte_o,
  output logic [1:0]            kind_o,
  output logic                  end_of_run_o
);
  import sse_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  kind_e      kind_q;
  logic       eor_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= res_i.char_byte;
      kind_q <= res_i.kind;
      eor_q  <= res_i.end_of_run;
    end
  end

  assign out_valid_o  = valid_q;
  assign char_byte_o  = char_q;
  assign kind_o       = kind_q;
  assign end_of_run_o = eor_q;

endmodule

`default_nettype wire

// ----- hdl/smbios_string_extractor_top.sv -----
// ----------------------------------------------------------------------------
// smbios_string_extractor_top
// Streams a raw SMBIOS table buffer and returns one structure string.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one table byte per request, first_byte_i starts a buffer,
//                 final_byte_i marks its last byte.
//   out channel : characters of the selected string (kind 0), then one
//                 verdict with end_of_run_o set; nothing more until the next
//                 first_byte_i.
//   cfg channel : target type (index 0) and string number offset (index 1),
//                 always ready; write only while the block is idle.
// Timing:
//   a request is registered in the input register on acceptance; its result,
//   if any, is loaded into the output register when the walker steps on it.
//   one byte per cycle sustained; the only limit is the output register
//   while the receiver stalls, then the input register fills and in_ready_o
//   drops until the held result is taken.
// Reset:
//   clears both stage valids and the walk state, restores register defaults
//   (type 1, offset 4); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module smbios_string_extractor_top #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       first_byte_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_byte_o,
  output logic [1:0]      kind_o,
  output logic            end_of_run_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [sse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import sse_pkg::*;

  logic [7:0] tt_q;
  logic [7:0] fo_q;

  logic      req_valid;
  byte_req_t req;
  result_t   res;
  logic      out_free;
  logic      step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_q <= TARGET_TYPE_RST;
      fo_q <= FIELD_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_TYPE:  tt_q <= cfg_data_i;
        CFG_FIELD_OFFSET: fo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step = req_valid && (!res.valid || out_free);

  sse_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .first_byte_i (first_byte_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .pop_i        (step),
    .valid_o      (req_valid),
    .req_o        (req)
  );

  sse_walker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .req_i          (req),
    .target_type_i  (tt_q),
    .field_offset_i (fo_q),
    .res_o          (res)
  );

  sse_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step && res.valid),
    .res_i        (res),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_byte_o  (char_byte_o),
    .kind_o       (kind_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule

`default_nettype wire

// ----- hdl/sse_checker.sv -----
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks of the SMBIOS string extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] char_byte_o,
  input wire logic [1:0] kind_o,
  input wire logic       end_of_run_o
);
  import sse_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(char_byte_o) && $stable(kind_o) && $stable(end_of_run_o))
    else $error("stalled result changed");

  // verdicts and only verdicts close a run
  a_eor_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_of_run_o == (kind_o != KIND_CHAR)))
    else $error("end_of_run does not match kind");

  // verdicts carry no character
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_CHAR |-> char_byte_o == 8'd0)
    else $error("verdict with nonzero character");

  // a fresh result follows an accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

endmodule

bind smbios_string_extractor_top sse_checker u_sse_checker (.*);

`default_nettype wire

// ----- sim/tb_smbios_string_extractor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smbios_string_extractor_top
// Self-checking bench for the SMBIOS string extractor. Raw table buffers are
// streamed in one byte per request: short directed buffers first, then random
// buffers under several register settings. Every buffer is walked by a
// behavioral copy of the lookup, and each returned character or verdict is
// compared with the oldest pending prediction. Both sides stall in random
// bursts, with one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_smbios_string_extractor_top;
  import sse_pkg::*;

  localparam int LEN_W          = 24;
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;
  localparam int NO_RESULT      = -1;
  localparam int N_PHASES       = 7;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int LONG_HOLD      = 64;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;

  localparam int ROW_MODEL = 0;
  localparam int ROW_NONE  = 1;
  localparam int ROW_FIXED = 2;

  localparam int SHAPE_CLEAN       = 0;
  localparam int SHAPE_SHORT_LEN   = 1;
  localparam int SHAPE_LONG_LEN    = 2;
  localparam int SHAPE_EARLY_END   = 3;
  localparam int SHAPE_CORRUPT     = 4;
  localparam int SHAPE_NOISE       = 5;
  localparam int SHAPE_LONG_STRING = 6;

  typedef enum logic [2:0] {
    W_HEADER, W_TYPE, W_LEN, W_FORMATTED, W_STRINGS
  } walk_phase_e;

  typedef struct {
    byte_req_t req;
    int        mode;
    result_t   want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 first_byte_i;
  logic [7:0]           data_byte_i;
  logic                 final_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           char_byte_o;
  logic [1:0]           kind_o;
  logic                 end_of_run_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  smbios_string_extractor_top #(
    .LENGTH_BITS(LEN_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .first_byte_i(first_byte_i),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_byte_o (char_byte_o),
    .kind_o      (kind_o),
    .end_of_run_o(end_of_run_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // lookup state mirrored from the block
  logic [7:0]  cur_type;
  logic [7:0]  cur_offset;
  walk_phase_e walk_ph;
  logic [31:0] pos;
  logic [31:0] tbl_len;
  logic [31:0] st_start;
  logic [7:0]  st_len;
  logic        st_match;
  logic [7:0]  num_or_type;
  logic [7:0]  str_idx;
  logic        last_zero;
  logic        verdict_done;

  result_t   awaited_q[$];
  byte_req_t pending_q[$];
  dir_row_t  dir_rows[$];

  bit quiet;
  int hold_asks;
  int holds_done;
  int live_items;
  int tables_sent;
  int results_seen;
  int chars_seen;
  int verdicts_seen;
  int error_count;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void restart_walk();
    walk_ph      = W_HEADER;
    pos          = '0;
    tbl_len      = '0;
    st_start     = '0;
    st_len       = '0;
    st_match     = 1'b0;
    num_or_type  = '0;
    str_idx      = '0;
    last_zero    = 1'b0;
    verdict_done = 1'b0;
  endfunction

  function automatic int open_struct(input logic [31:0] s);
    st_start = s;
    st_match = 1'b0;
    walk_ph  = W_TYPE;
    if (64'(s) + 64'(MIN_LEN) > 64'(tbl_len)) return KIND_NONE;
    return NO_RESULT;
  endfunction

  // one step of the table walk; returns 1 when the byte yields a result
  function automatic bit walk_byte(input logic f, input logic [7:0] b, input logic l,
                                   output result_t res);
    int          k;
    logic [7:0]  ch;
    logic [31:0] rel;
    logic [31:0] off;
    res = '0;
    k   = NO_RESULT;
    ch  = '0;
    if (f) restart_walk();
    if (verdict_done) return 1'b0;
    if (walk_ph == W_HEADER) begin
      if (pos >= 4 && pos < HEADER_BYTES) tbl_len |= 32'(b) << (8 * (pos - 4));
      pos++;
      if (pos >= HEADER_BYTES) begin
        if (64'(tbl_len) > LEN_MAX) tbl_len = LEN_MAX[31:0];
        pos = '0;
        k   = open_struct('0);
      end
    end else begin
      rel = pos;
      case (walk_ph)
        W_TYPE: begin
          num_or_type = b;
          walk_ph     = W_LEN;
        end
        W_LEN: begin
          st_len = b;
          if (b < MIN_LEN || 64'(st_start) + 64'(b) + 64'd2 > 64'(tbl_len)) begin
            k = KIND_BAD;
          end else if (num_or_type == END_TYPE) begin
            k = KIND_NONE;
          end else begin
            st_match = (num_or_type == cur_type) && (cur_offset < b);
            if (cur_offset == 8'd1) num_or_type = b;
            walk_ph = W_FORMATTED;
          end
        end
        W_FORMATTED: begin
          off = rel - st_start;
          if (st_match && off == 32'(cur_offset)) num_or_type = b;
          if (off + 32'd1 >= 32'(st_len)) begin
            if (st_match && num_or_type == 8'd0) begin
              k = KIND_NONE;
            end else begin
              walk_ph   = W_STRINGS;
              str_idx   = 8'd1;
              last_zero = st_match;
            end
          end
        end
        default: begin
          if (st_match) begin
            if (last_zero && b == 8'd0) begin
              k = KIND_NONE;
            end else if (str_idx == num_or_type) begin
              if (b == 8'd0) begin
                k = KIND_DONE;
              end else begin
                k  = KIND_CHAR;
                ch = b;
              end
              last_zero = 1'b0;
            end else begin
              if (b == 8'd0) str_idx++;
              last_zero = (b == 8'd0);
            end
          end else begin
            if (b == 8'd0 && last_zero) k = open_struct(rel + 32'd1);
            else last_zero = (b == 8'd0);
          end
        end
      endcase
      if (k == NO_RESULT || k == KIND_CHAR) begin
        pos = rel + 32'd1;
        if (64'(rel) + 64'd1 >= 64'(tbl_len)) k = st_match ? KIND_BAD : KIND_NONE;
      end
    end
    if ((k == NO_RESULT || k == KIND_CHAR) && l) k = KIND_BAD;
    if (k == NO_RESULT) return 1'b0;
    if (k != KIND_CHAR) begin
      ch           = '0;
      verdict_done = 1'b1;
    end
    res.valid      = 1'b1;
    res.char_byte  = ch;
    res.kind       = kind_e'(k);
    res.end_of_run = (k != KIND_CHAR);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch in %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
  endtask

  task automatic queue_byte(input logic f, input logic [7:0] d, input logic l);
    pending_q.push_back({f, d, l});
  endtask

  task automatic add_row(input logic f, input logic [7:0] d, input logic l, input int mode,
                         input logic [7:0] ch, input kind_e k);
    dir_row_t row;
    row.req                 = {f, d, l};
    row.mode                = mode;
    row.want.valid          = 1'b1;
    row.want.char_byte      = ch;
    row.want.kind           = k;
    row.want.end_of_run     = (k != KIND_CHAR);
    dir_rows.push_back(row);
  endtask

  task automatic send_byte(input byte_req_t req, output bit has_res, output result_t res);
    int gap;
    if (!quiet && hold_asks == holds_done && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    first_byte_i <= req.first_byte;
    data_byte_i  <= req.data_byte;
    final_byte_i <= req.final_byte;
    do @(posedge clk_i); while (!in_ready_o);
    live_items++;
    has_res = walk_byte(req.first_byte, req.data_byte, req.final_byte, res);
  endtask

  task automatic send_pending();
    bit      has_res;
    result_t res;
    foreach (pending_q[i]) begin
      send_byte(pending_q[i], has_res, res);
      if (has_res) awaited_q.push_back(res);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] ty, input logic [7:0] off);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TARGET_TYPE;
    cfg_data_i  <= ty;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_type    = ty;
    cfg_index_i <= CFG_FIELD_OFFSET;
    cfg_data_i  <= off;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_offset  = off;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic build_table(input int shape);
    logic [7:0]  body[$];
    logic [7:0]  ty;
    logic [7:0]  num;
    logic [31:0] tlen;
    int          len;
    int          nstr;
    int          clen;
    int          r;
    int          cut;
    int          total;
    bit          is_long;
    pending_q.delete();
    tables_sent++;
    if (shape == SHAPE_NOISE) begin
      total = $urandom_range(4, 30);
      for (int i = 0; i < total; i++)
        queue_byte(i == 0 || $urandom_range(0, 15) == 0, 8'($urandom),
                   i == total - 1 || $urandom_range(0, 15) == 0);
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      is_long = (shape == SHAPE_LONG_STRING) && body.size() == 0;
      r = $urandom_range(0, 9);
      if (is_long || r < 5) ty = cur_type;
      else if (r == 5) ty = END_TYPE;
      else ty = 8'($urandom);
      if (ty == cur_type && cur_offset < 60 && (is_long || $urandom_range(0, 3) != 0))
        len = int'(cur_offset) + 1 + $urandom_range(0, 3);
      else if ($urandom_range(0, 40) == 0) len = $urandom_range(13, 255);
      else len = $urandom_range(MIN_LEN, 12);
      if (len < MIN_LEN) len = MIN_LEN;
      nstr = is_long ? 1 : $urandom_range(0, 3);
      r = $urandom_range(0, 9);
      if (is_long) num = 8'd1;
      else if (r < 7 && nstr > 0) num = 8'($urandom_range(1, nstr));
      else if (r < 8) num = 8'd0;
      else num = 8'(nstr + 1);
      body.push_back(ty);
      body.push_back(8'(len));
      for (int k = 2; k < len; k++) body.push_back(k == int'(cur_offset) ? num : 8'($urandom));
      for (int j = 0; j < nstr; j++) begin
        clen = is_long ? 24 : $urandom_range(1, 5);
        repeat (clen) body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
      end
      if (nstr == 0) body.push_back(8'h00);
      body.push_back(8'h00);
    end
    // end-of-table structure on most tables
    if ($urandom_range(0, 3) != 0) begin
      body.push_back(END_TYPE);
      body.push_back(8'(MIN_LEN));
      repeat (4) body.push_back(8'h00);
    end
    if (shape == SHAPE_CORRUPT) begin
      if ($urandom_range(0, 1) == 0) body[1] = 8'($urandom_range(0, MIN_LEN - 1));
      else body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    end
    tlen = body.size();
    if (shape == SHAPE_SHORT_LEN)
      tlen = $urandom_range(0, body.size() - 1);
    else if (shape == SHAPE_LONG_LEN)
      tlen = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h0100_0000)
                                         : tlen + $urandom_range(1, 16);
    total = HEADER_BYTES + body.size();
    cut   = (shape == SHAPE_EARLY_END) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < cut; i++)
      queue_byte(i == 0,
                 (i < 4) ? 8'($urandom) :
                 (i < HEADER_BYTES) ? tlen[8*(i-4) +: 8] : body[i - HEADER_BYTES],
                 i == cut - 1 && (shape != SHAPE_CLEAN || $urandom_range(0, 9) != 0));
  endtask

  // output side: random stalls plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    holds_done  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_done++;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (kind_o == KIND_CHAR) chars_seen++;
      else verdicts_seen++;
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected result kind", 8'(kind_o), 8'd0);
      end else begin
        exp_res = awaited_q.pop_front();
        if (char_byte_o !== exp_res.char_byte)
          report_mismatch("char_byte", char_byte_o, exp_res.char_byte);
        if (kind_o !== exp_res.kind)
          report_mismatch("kind", 8'(kind_o), 8'(exp_res.kind));
        if (end_of_run_o !== exp_res.end_of_run)
          report_mismatch("end_of_run", 8'(end_of_run_o), 8'(exp_res.end_of_run));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, awaited_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_type[N_PHASES];
    logic [7:0] phase_off[N_PHASES];
    bit         has_res;
    result_t    res;
    int         goal;
    int         r;
    int         shape;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    first_byte_i = 1'b0;
    data_byte_i  = '0;
    final_byte_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    hold_asks    = 0;
    error_count  = 0;
    idle_cycles  = 0;
    cur_type     = TARGET_TYPE_RST;
    cur_offset   = FIELD_OFFSET_RST;
    restart_walk();
    phase_type = '{8'h00, 8'hFF, 8'h01, 8'h7F, 8'($urandom), 8'($urandom), 8'h11};
    phase_off  = '{8'h00, 8'hFF, 8'h01, 8'h05, 8'($urandom_range(0, 12)),
                   8'($urandom_range(0, 12)), 8'h02};

    // zero table length: nothing to walk
    add_row(1'b1, 8'hFF, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'hFF, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    repeat (3) add_row(1'b0, 8'h00, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_FIXED, 8'h00, KIND_NONE);
    // ignored after the verdict
    add_row(1'b0, 8'hAA, 1'b1, ROW_NONE, 8'h00, KIND_CHAR);
    // buffer that ends on its first byte
    add_row(1'b1, 8'h00, 1'b1, ROW_FIXED, 8'h00, KIND_BAD);
    // oversized length, then a match on string one
    add_row(1'b1, 8'h5A, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'hA5, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'hFF, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    repeat (4) add_row(1'b0, 8'hFF, 1'b0, ROW_NONE, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h01, 1'b0, ROW_MODEL, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h05, 1'b0, ROW_MODEL, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'hFF, 1'b0, ROW_MODEL, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_MODEL, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h01, 1'b0, ROW_MODEL, 8'h00, KIND_CHAR);
    add_row(1'b0, 8'h41, 1'b0, ROW_FIXED, 8'h41, KIND_CHAR);
    add_row(1'b0, 8'h00, 1'b0, ROW_FIXED, 8'h00, KIND_DONE);
    add_row(1'b0, 8'h80, 1'b1, ROW_NONE, 8'h00, KIND_CHAR);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].req, has_res, res);
      if (dir_rows[i].mode == ROW_FIXED) awaited_q.push_back(dir_rows[i].want);
      else if (dir_rows[i].mode == ROW_MODEL && has_res) awaited_q.push_back(res);
    end
    settle();

    // long output stall while a long string keeps coming
    hold_asks++;
    tables_sent = 0;
    build_table(SHAPE_LONG_STRING);
    send_pending();
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      quiet = (p == N_PHASES - 1);
      set_config(phase_type[p], phase_off[p]);
      goal = live_items + ITEMS_PER_PHASE;
      while (live_items < goal) begin
        r = $urandom_range(0, 19);
        if (r < 11) shape = SHAPE_CLEAN;
        else if (r < 13) shape = SHAPE_SHORT_LEN;
        else if (r < 15) shape = SHAPE_LONG_LEN;
        else if (r < 17) shape = SHAPE_EARLY_END;
        else if (r < 19) shape = SHAPE_CORRUPT;
        else shape = SHAPE_NOISE;
        build_table(shape);
        send_pending();
      end
      settle();
    end

    $display("sent %0d table bytes in %0d random buffers over %0d register settings",
             live_items, tables_sent, N_PHASES + 1);
    $display("checked %0d results: %0d characters and %0d verdicts, %0d mismatches",
             results_seen, chars_seen, verdicts_seen, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sse_pkg.sv
hdl/sse_in_stage.sv
hdl/sse_walker.sv
hdl/sse_out_stage.sv
hdl/smbios_string_extractor_top.sv
hdl/sse_checker.sv
sim/tb_smbios_string_extractor_top.sv
